FILE: design/vclru_pkg.sv
// vclru_pkg: shared types and constants for the victim cache LRU unit.
// Holds the command codes, controller states and controller/datapath links.
// No dependencies.
package vclru_pkg;

  // Default geometry
  localparam int ENTRIES_DEF       = 8;
  localparam int TAG_WIDTH_DEF     = 26;
  localparam int PAYLOAD_WIDTH_DEF = 8;
  localparam int CMD_W             = 2;

  // Command codes
  typedef enum logic [CMD_W-1:0] {
    CMD_LOOKUP    = 2'd0,
    CMD_INSERT    = 2'd1,
    CMD_EVICT     = 2'd2,
    CMD_OVERWRITE = 2'd3
  } cmd_t;

  // Controller states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_COMMIT
  } state_t;

  // Controller to datapath commands
  typedef struct packed {
    logic load;    // capture request, restart the scan
    logic scan;    // step the entry scan
    logic commit;  // apply the update and register the result
  } dp_ctrl_t;

  // Datapath to controller status
  typedef struct packed {
    logic scan_done;  // last entry compared this cycle
  } dp_stat_t;

endpackage

FILE: design/vclru_ctrl.sv
// vclru_ctrl: controller state machine for the victim cache LRU unit.
// Sequences load, entry scan and commit. Depends on vclru_pkg.
module vclru_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  input  vclru_pkg::dp_stat_t stat,
  output vclru_pkg::dp_ctrl_t ctrl
);

  vclru_pkg::state_t state, state_next;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= vclru_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      vclru_pkg::ST_IDLE: begin
        if (start) state_next = vclru_pkg::ST_SCAN;
      end
      vclru_pkg::ST_SCAN: begin
        if (stat.scan_done) state_next = vclru_pkg::ST_COMMIT;
      end
      vclru_pkg::ST_COMMIT: begin
        state_next = vclru_pkg::ST_IDLE;
      end
      default: begin
        state_next = vclru_pkg::ST_IDLE;
      end
    endcase
  end

  // Outputs
  always_comb begin
    ctrl = '0;
    busy = 1'b1;
    case (state)
      vclru_pkg::ST_IDLE: begin
        busy      = 1'b0;
        ctrl.load = start;
      end
      vclru_pkg::ST_SCAN: begin
        ctrl.scan = 1'b1;
      end
      vclru_pkg::ST_COMMIT: begin
        ctrl.commit = 1'b1;
      end
      default: begin
        busy = 1'b1;
      end
    endcase
  end

endmodule

FILE: design/vclru_dp.sv
// vclru_dp: datapath of the victim cache LRU unit.
// Tag and payload memories, valid bits, age ranking, scan and result registers.
// Depends on vclru_pkg.
module vclru_dp #(
  parameter int ENTRIES       = vclru_pkg::ENTRIES_DEF,
  parameter int TAG_WIDTH     = vclru_pkg::TAG_WIDTH_DEF,
  parameter int PAYLOAD_WIDTH = vclru_pkg::PAYLOAD_WIDTH_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  vclru_pkg::dp_ctrl_t         ctrl,
  output vclru_pkg::dp_stat_t         stat,
  input  logic [vclru_pkg::CMD_W-1:0] command,
  input  logic [TAG_WIDTH-1:0]        addr_tag,
  input  logic [PAYLOAD_WIDTH-1:0]    block_payload,
  output logic                        done,
  output logic                        hit,
  output logic                        block_valid,
  output logic [TAG_WIDTH-1:0]        block_tag,
  output logic [PAYLOAD_WIDTH-1:0]    block_out_payload
);

  localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam logic [IDX_W-1:0] LAST = IDX_W'(ENTRIES - 1);

  // Request registers
  vclru_pkg::cmd_t           req_cmd;
  logic [TAG_WIDTH-1:0]      req_tag;
  logic [PAYLOAD_WIDTH-1:0]  req_pay;

  // Storage
  logic [TAG_WIDTH-1:0]      tag_mem [ENTRIES];
  logic [PAYLOAD_WIDTH-1:0]  data_mem [ENTRIES];
  logic [ENTRIES-1:0]        valid;
  logic [IDX_W-1:0]          age [ENTRIES];

  // Scan pipeline
  logic                      issue;
  logic [IDX_W-1:0]          rd_idx;
  logic                      cmp_valid;
  logic [IDX_W-1:0]          cmp_idx;
  logic [TAG_WIDTH-1:0]      rd_tag;
  logic [PAYLOAD_WIDTH-1:0]  rd_pay;

  // Scan results
  logic                      found;
  logic [IDX_W-1:0]          m_idx;
  logic [IDX_W-1:0]          m_age;
  logic [TAG_WIDTH-1:0]      m_tag;
  logic [PAYLOAD_WIDTH-1:0]  m_pay;
  logic                      inv_found;
  logic [IDX_W-1:0]          inv_idx;
  logic [IDX_W-1:0]          inv_age;
  logic [IDX_W-1:0]          best_idx;
  logic [IDX_W-1:0]          best_age;

  // Compare stage
  logic                      cur_valid;
  logic [IDX_W-1:0]          cur_age;
  logic                      cur_match;

  // Commit selection
  logic                      wr_en;
  logic [IDX_W-1:0]          sel_idx;
  logic [IDX_W-1:0]          sel_age;
  logic                      evict_hit;

  assign cur_valid = valid[cmp_idx];
  assign cur_age   = age[cmp_idx];
  assign cur_match = cur_valid && (rd_tag == req_tag);
  assign stat.scan_done = cmp_valid && (cmp_idx == LAST);

  // Entry chosen for the write and its old age
  always_comb begin
    wr_en   = 1'b0;
    sel_idx = m_idx;
    sel_age = m_age;
    case (req_cmd)
      vclru_pkg::CMD_INSERT: begin
        wr_en   = ctrl.commit;
        sel_idx = inv_found ? inv_idx : best_idx;
        sel_age = inv_found ? inv_age : best_age;
      end
      vclru_pkg::CMD_OVERWRITE: begin
        wr_en = ctrl.commit && found;
      end
      default: begin
        wr_en = 1'b0;
      end
    endcase
  end

  assign evict_hit = (req_cmd == vclru_pkg::CMD_EVICT) && found;

  // Request capture
  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      req_cmd <= vclru_pkg::cmd_t'(command);
      req_tag <= addr_tag;
      req_pay <= block_payload;
    end
  end

  // Tag and payload memories, registered read at the scan index
  always_ff @(posedge clk) begin
    if (wr_en) begin
      tag_mem[sel_idx]  <= req_tag;
      data_mem[sel_idx] <= req_pay;
    end
    rd_tag <= tag_mem[rd_idx];
    rd_pay <= data_mem[rd_idx];
  end

  // Read issue and compare index
  always_ff @(posedge clk) begin
    if (rst) begin
      issue     <= 1'b0;
      rd_idx    <= '0;
      cmp_valid <= 1'b0;
      cmp_idx   <= '0;
    end else if (ctrl.load) begin
      issue     <= 1'b1;
      rd_idx    <= '0;
      cmp_valid <= 1'b0;
    end else if (ctrl.scan) begin
      cmp_valid <= issue;
      cmp_idx   <= rd_idx;
      if (issue) begin
        if (rd_idx == LAST) begin
          issue <= 1'b0;
        end else begin
          rd_idx <= rd_idx + 1'b1;
        end
      end
    end else begin
      cmp_valid <= 1'b0;
    end
  end

  // Scan results: first match, first invalid entry, oldest entry
  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      found     <= 1'b0;
      inv_found <= 1'b0;
      best_idx  <= '0;
      best_age  <= '0;
    end else if (ctrl.scan && cmp_valid) begin
      if (cur_match && !found) begin
        found <= 1'b1;
        m_idx <= cmp_idx;
        m_age <= cur_age;
        m_tag <= rd_tag;
        m_pay <= rd_pay;
      end
      if (!cur_valid && !inv_found) begin
        inv_found <= 1'b1;
        inv_idx   <= cmp_idx;
        inv_age   <= cur_age;
      end
      if (cur_age > best_age) begin
        best_idx <= cmp_idx;
        best_age <= cur_age;
      end
    end
  end

  // Valid bits and age ranking
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
      for (int i = 0; i < ENTRIES; i++) begin
        age[i] <= IDX_W'(i);
      end
    end else if (ctrl.commit) begin
      if (wr_en) begin
        valid[sel_idx] <= 1'b1;
        for (int i = 0; i < ENTRIES; i++) begin
          if (age[i] < sel_age) age[i] <= age[i] + 1'b1;
        end
        age[sel_idx] <= '0;
      end else if (evict_hit) begin
        valid[m_idx] <= 1'b0;
      end
    end
  end

  // Result registers
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= ctrl.commit;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.commit) begin
      hit               <= found;
      block_valid       <= evict_hit;
      block_tag         <= evict_hit ? m_tag : '0;
      block_out_payload <= evict_hit ? m_pay : '0;
    end
  end

endmodule

FILE: design/victim_cache_lru_unit.sv
// victim_cache_lru_unit: top level of the fully associative LRU victim cache.
// Joins vclru_ctrl and vclru_dp. Depends on vclru_pkg.
//
// Usage:
//   A request (command, addr_tag, block_payload) transfers at a rising edge
//   with start high and busy low. Commands: lookup, insert, evict, overwrite.
//   The unit scans the entries one per cycle through a single read port of
//   the tag/payload memories, then commits the update.
//   The result (hit, block_valid, block_tag, block_out_payload) is shown for
//   exactly one cycle with done high; it transfers at the edge that ends
//   that cycle. The receiver cannot hold it off.
//   No new request is taken while busy is high, through the entry scan and
//   the commit; busy drops while done is shown, so the next request may
//   transfer in the same cycle as the result.
//   Reset (rst, synchronous, active high): all entries invalid, entry i gets
//   age i, controller idle, no result pending. Tag and payload memories are
//   not cleared; they are only read back from valid entries.
module victim_cache_lru_unit #(
  parameter int ENTRIES       = vclru_pkg::ENTRIES_DEF,
  parameter int TAG_WIDTH     = vclru_pkg::TAG_WIDTH_DEF,
  parameter int PAYLOAD_WIDTH = vclru_pkg::PAYLOAD_WIDTH_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  output logic                        busy,
  input  logic [vclru_pkg::CMD_W-1:0] command,
  input  logic [TAG_WIDTH-1:0]        addr_tag,
  input  logic [PAYLOAD_WIDTH-1:0]    block_payload,
  output logic                        done,
  output logic                        hit,
  output logic                        block_valid,
  output logic [TAG_WIDTH-1:0]        block_tag,
  output logic [PAYLOAD_WIDTH-1:0]    block_out_payload
);

  vclru_pkg::dp_ctrl_t ctrl;
  vclru_pkg::dp_stat_t stat;

  // Controller
  vclru_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .stat  (stat),
    .ctrl  (ctrl)
  );

  // Datapath
  vclru_dp #(
    .ENTRIES       (ENTRIES),
    .TAG_WIDTH     (TAG_WIDTH),
    .PAYLOAD_WIDTH (PAYLOAD_WIDTH)
  ) u_dp (
    .clk               (clk),
    .rst               (rst),
    .ctrl              (ctrl),
    .stat              (stat),
    .command           (command),
    .addr_tag          (addr_tag),
    .block_payload     (block_payload),
    .done              (done),
    .hit               (hit),
    .block_valid       (block_valid),
    .block_tag         (block_tag),
    .block_out_payload (block_out_payload)
  );

endmodule

FILE: dv/victim_cache_lru_unit_test.sv
// victim_cache_lru_unit_test: self-checking testbench for the LRU victim cache.
// Directed and random command traffic is checked against a cycle-free shadow model.
// Depends on vclru_pkg and victim_cache_lru_unit.
module victim_cache_lru_unit_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int N       = vclru_pkg::ENTRIES_DEF;
  localparam int TW      = vclru_pkg::TAG_WIDTH_DEF;
  localparam int PW      = vclru_pkg::PAYLOAD_WIDTH_DEF;
  localparam int AGE_W   = (N > 1) ? $clog2(N) : 1;
  localparam int STALL_LIMIT = 300;
  localparam int PHASE_ITEMS = 460;

  typedef struct {
    bit          hit;
    bit          blk_valid;
    bit [TW-1:0] blk_tag;
    bit [PW-1:0] blk_pay;
  } vc_response_t;

  // Shadow copy of the cache: predicts each response when its request transfers
  class victim_cache_shadow;
    bit              valid [N];
    bit [TW-1:0]     tags  [N];
    bit [PW-1:0]     data  [N];
    bit [AGE_W-1:0]  age   [N];
    vc_response_t    pending_responses[$];
    int errors, requests, hits, evict_returns, replacements;

    function new();
      for (int i = 0; i < N; i++) begin
        valid[i] = 1'b0;
        tags[i]  = '0;
        data[i]  = '0;
        age[i]   = AGE_W'(i);
      end
    endfunction

    // younger entries age by one, the chosen entry becomes age 0
    function void promote(int sel);
      bit [AGE_W-1:0] was;
      was = age[sel];
      for (int i = 0; i < N; i++)
        if (age[i] < was) age[i]++;
      age[sel] = '0;
    endfunction

    function void record_request(vclru_pkg::cmd_t cmd, bit [TW-1:0] tag, bit [PW-1:0] pay);
      int m;
      int slot;
      vc_response_t r;
      m = -1;
      for (int i = 0; i < N; i++)
        if (m < 0 && valid[i] && tags[i] == tag) m = i;
      r = '{hit: (m >= 0), blk_valid: 1'b0, blk_tag: '0, blk_pay: '0};
      requests++;
      if (m >= 0) hits++;
      case (cmd)
        vclru_pkg::CMD_INSERT: begin
          // lowest free entry, else the oldest (lowest index on a tie)
          slot = -1;
          for (int i = 0; i < N; i++)
            if (slot < 0 && !valid[i]) slot = i;
          if (slot < 0) begin
            slot = 0;
            for (int i = 1; i < N; i++)
              if (age[i] > age[slot]) slot = i;
            replacements++;
          end
          valid[slot] = 1'b1;
          tags[slot]  = tag;
          data[slot]  = pay;
          promote(slot);
        end
        vclru_pkg::CMD_EVICT: begin
          if (m >= 0) begin
            r.blk_valid = 1'b1;
            r.blk_tag   = tags[m];
            r.blk_pay   = data[m];
            valid[m]    = 1'b0;
            evict_returns++;
          end
        end
        vclru_pkg::CMD_OVERWRITE: begin
          if (m >= 0) begin
            tags[m] = tag;
            data[m] = pay;
            promote(m);
          end
        end
        default: ;
      endcase
      pending_responses.push_back(r);
    endfunction

    function void compare_field(string name, bit [63:0] want, bit [63:0] got);
      if (want !== got) begin
        $display("%0t: %s mismatch, expected %0h actual %0h", $realtime, name, want, got);
        errors++;
      end
    endfunction

    function void check_response(logic h, logic bv, logic [TW-1:0] bt, logic [PW-1:0] bp);
      vc_response_t want;
      if (pending_responses.size() == 0) begin
        $display("%0t: response with none outstanding, expected nothing actual %0h/%0h/%0h/%0h",
                 $realtime, h, bv, bt, bp);
        errors++;
        return;
      end
      want = pending_responses.pop_front();
      compare_field("hit", 64'(want.hit), 64'(h));
      compare_field("block_valid", 64'(want.blk_valid), 64'(bv));
      compare_field("block_tag", 64'(want.blk_tag), 64'(bt));
      compare_field("block_out_payload", 64'(want.blk_pay), 64'(bp));
    endfunction

    function int outstanding();
      return pending_responses.size();
    endfunction
  endclass

  logic          clk = 1'b0;
  logic          rst = 1'b1;
  logic          start = 1'b0;
  logic [vclru_pkg::CMD_W-1:0] command = '0;
  logic [TW-1:0] addr_tag = '0;
  logic [PW-1:0] block_payload = '0;
  logic          busy, done, hit, block_valid;
  logic [TW-1:0] block_tag;
  logic [PW-1:0] block_out_payload;

  victim_cache_shadow shadow = new();
  int idle_pct;
  int stall_count;
  bit [TW-1:0] tag_pool [12];

  victim_cache_lru_unit u_top (
    .clk, .rst, .start, .busy, .command, .addr_tag, .block_payload,
    .done, .hit, .block_valid, .block_tag, .block_out_payload
  );

  always #5 clk = ~clk;

  // Observe transfers on both sides at each edge
  always @(posedge clk) begin
    if (!rst) begin
      if (done) shadow.check_response(hit, block_valid, block_tag, block_out_payload);
      if (start && !busy)
        shadow.record_request(vclru_pkg::cmd_t'(command), addr_tag, block_payload);
    end
  end

  // Watchdog: too long without any transfer ends the run
  always @(posedge clk) begin
    if (rst || (start && !busy) || done) begin
      stall_count <= 0;
    end else if (stall_count >= STALL_LIMIT) begin
      $display("%0t: no transfer for %0d cycles", $realtime, STALL_LIMIT);
      $display("[FAIL] regression broken");
      $finish;
    end else begin
      stall_count <= stall_count + 1;
    end
  end

  // One request: optional idle cycles, then hold start until it transfers
  task automatic issue(vclru_pkg::cmd_t cmd, bit [TW-1:0] tag, bit [PW-1:0] pay);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start         <= 1'b1;
    command       <= cmd;
    addr_tag      <= tag;
    block_payload <= pay;
    do @(posedge clk); while (busy);
  endtask

  // Hold off until every predicted response has come back
  task automatic drain();
    start <= 1'b0;
    do @(posedge clk); while (shadow.outstanding() != 0);
  endtask

  task automatic refresh_tags();
    for (int i = 0; i < 12; i++)
      case ($urandom_range(9))
        0:       tag_pool[i] = '0;
        1:       tag_pool[i] = '1;
        default: tag_pool[i] = TW'($urandom);
      endcase
  endtask

  // Corner cases: empty cache, duplicates, lowest-index match, fill and LRU replacement
  task automatic run_directed();
    issue(vclru_pkg::CMD_LOOKUP, '0, 8'h00);         // miss on empty cache
    issue(vclru_pkg::CMD_EVICT, '1, 8'hff);          // evict miss
    issue(vclru_pkg::CMD_OVERWRITE, '0, 8'h5a);      // overwrite miss changes nothing
    issue(vclru_pkg::CMD_INSERT, '0, 8'h00);
    issue(vclru_pkg::CMD_INSERT, '1, 8'hff);
    issue(vclru_pkg::CMD_INSERT, '0, 8'h55);         // duplicate tag
    issue(vclru_pkg::CMD_LOOKUP, '0, 8'h00);
    issue(vclru_pkg::CMD_OVERWRITE, '0, 8'haa);      // hits lowest index
    issue(vclru_pkg::CMD_EVICT, '0, 8'h00);
    issue(vclru_pkg::CMD_EVICT, '0, 8'h00);          // second copy
    issue(vclru_pkg::CMD_LOOKUP, '1, 8'h00);
    for (int i = 0; i < N - 1; i++)
      issue(vclru_pkg::CMD_INSERT, TW'(1) << (3 * i + 2), PW'(8'h11 * (i + 1)));
    issue(vclru_pkg::CMD_LOOKUP, TW'(1) << 2, 8'h00); // full cache
    issue(vclru_pkg::CMD_OVERWRITE, '1, 8'h3c);       // refresh recency
    issue(vclru_pkg::CMD_INSERT, TW'(26'h2aaaaaa), 8'h81); // replace oldest
    issue(vclru_pkg::CMD_INSERT, TW'(26'h1555555), 8'h7e);
    issue(vclru_pkg::CMD_EVICT, '1, 8'h00);
    issue(vclru_pkg::CMD_LOOKUP, TW'(26'h2aaaaaa), 8'h00);
  endtask

  task automatic run_random(int count);
    int pick;
    vclru_pkg::cmd_t cmd;
    bit [TW-1:0] tag;
    for (int n = 0; n < count; n++) begin
      if (n % 150 == 0) refresh_tags();
      if ($urandom_range(99) == 0) drain();
      pick = $urandom_range(99);
      if (pick < 35)      cmd = vclru_pkg::CMD_INSERT;
      else if (pick < 60) cmd = vclru_pkg::CMD_LOOKUP;
      else if (pick < 80) cmd = vclru_pkg::CMD_EVICT;
      else                cmd = vclru_pkg::CMD_OVERWRITE;
      // mostly reused tags so hits and replacements are frequent
      if ($urandom_range(9) == 0) tag = TW'($urandom);
      else                        tag = tag_pool[$urandom_range(11)];
      issue(cmd, tag, PW'($urandom_range(255)));
    end
  endtask

  initial begin
    idle_pct = 6;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    run_directed();
    // sender idle profiles: light, heavy, none
    run_random(PHASE_ITEMS);
    drain();
    idle_pct = 61;
    run_random(PHASE_ITEMS);
    drain();
    idle_pct = 0;
    run_random(PHASE_ITEMS);
    drain();
    repeat (N + 4) @(posedge clk);
    $display("Covered %0d requests: %0d hits, %0d evict returns, %0d LRU replacements,",
             shadow.requests, shadow.hits, shadow.evict_returns, shadow.replacements);
    $display("under light, heavy and no sender idling; %0d mismatches.", shadow.errors);
    if (shadow.errors == 0 && shadow.outstanding() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
